@@ src/brbf_pkg.sv @@
// ----------------------------------------------------------------------------
// brbf_pkg
// Shared types and constants for the byte ring buffer FIFO: command codes,
// transaction payloads, controller states and the ring geometry.
// ----------------------------------------------------------------------------
package brbf_pkg;

  // Ring geometry: storage depth, slot index width and slot count width.
  localparam int unsigned DEPTH  = 64;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned SIZE_W = $clog2(DEPTH + 1);

  // Bounds that a written slot count is clamped to.
  localparam logic [SIZE_W-1:0] RING_MIN = SIZE_W'(2);
  localparam logic [SIZE_W-1:0] RING_MAX = SIZE_W'(DEPTH);

  // Command codes carried in the input transaction.
  typedef enum logic [2:0] {
    CMD_OVR_PUT = 3'd0,
    CMD_TRY_PUT = 3'd1,
    CMD_GET     = 3'd2,
    CMD_PEEK    = 3'd3,
    CMD_RESET   = 3'd4
  } cmd_e;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_PEEK
  } state_e;

  // Input transaction payload.
  typedef struct packed {
    logic [2:0] command;
    logic [7:0] write_byte;
    logic [5:0] peek_count;
  } in_item_t;

  // Result transaction payload.
  typedef struct packed {
    logic [7:0] read_byte;
    logic       ok;
    logic [5:0] level;
    logic       is_empty;
    logic       is_full;
    logic       last_of_run;
  } out_item_t;

  // A result handed from the controller to the output queue.
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_push_t;

  // Slot memory access request from the controller.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

@@ src/byte_ring_buffer_fifo_unit.sv @@
// ----------------------------------------------------------------------------
// byte_ring_buffer_fifo_unit
// Byte FIFO over a ring of up to 64 slots with one slot kept free.
// ----------------------------------------------------------------------------
// Path: a taken command's result passes the slot memory read with the result
// stage, then the output queue register, before it can leave.
// Flow: put, get, reset and refused commands give one result each; a peek of
// N bytes gives N results, one slot memory read per result, and holds further
// commands off until its last read; input stalls while the queue lacks room.
// Reset: pointers clear and the slot count returns to 64 at once; the slot
// memory is not cleared and has no clearing pass.
module byte_ring_buffer_fifo_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  brbf_pkg::in_item_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output brbf_pkg::out_item_t            out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [brbf_pkg::SIZE_W-1:0]    cfg_data_i
);
  import brbf_pkg::*;

  res_push_t  push;
  ram_req_t   ram_req;
  logic [7:0] ram_rdata;
  logic [1:0] occ;
  logic       cfg_fire;

  // The slot count register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  // Pointer controller.
  brbf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .cfg_valid_i (cfg_fire),
    .cfg_data_i  (cfg_data_i),
    .occ_i       (occ),
    .push_o      (push),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  // Slot storage.
  brbf_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  // Output queue.
  brbf_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .occ_o       (occ),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTH
  // A result is only pushed when the output queue has room for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.valid |-> (occ == 2'd0 || occ == 2'd1))
    else $error("output queue overflow");

  // Only a successful peek produces results that are not the last of a run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.last_of_run) |-> out_data_o.ok)
    else $error("unmarked result on a refused command");

  // A refused transaction never carries data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.ok) |-> (out_data_o.read_byte == 8'd0))
    else $error("refused result carries data");

  // The empty flag agrees with a zero level.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.is_empty == (out_data_o.level == 6'd0)))
    else $error("empty flag and level disagree");
`endif

endmodule

@@ src/brbf_ram.sv @@
// ----------------------------------------------------------------------------
// brbf_ram
// Generic simple dual-port RAM: one write port and one read port, with the
// read data registered.
// ----------------------------------------------------------------------------
module brbf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/brbf_outq.sv @@
// ----------------------------------------------------------------------------
// brbf_outq
// Two-entry result queue between the controller and the output channel. It
// reports its occupancy after this cycle's pop so that the controller can
// issue only when a slot is guaranteed for the result.
// ----------------------------------------------------------------------------
module brbf_outq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  brbf_pkg::res_push_t  push_i,
  output logic [1:0]           occ_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output brbf_pkg::out_item_t  out_data_o
);
  import brbf_pkg::*;

  out_item_t  ent_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wr_q, rd_q;
  logic       pop;

  // A transaction leaves when the head entry is valid and not stalled.
  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o && !out_stall_i;
  assign out_data_o  = ent_q[rd_q];
  assign occ_o       = cnt_q - {1'b0, pop};
  assign cnt_d       = cnt_q + {1'b0, push_i.valid} - {1'b0, pop};

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      ent_q[wr_q] <= push_i.item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i.valid) begin
        wr_q <= !wr_q;
      end
      if (pop) begin
        rd_q <= !rd_q;
      end
    end
  end

endmodule

@@ src/brbf_ctrl.sv @@
// ----------------------------------------------------------------------------
// brbf_ctrl
// Ring pointer controller. Decodes commands, updates head and tail, issues
// slot memory writes and reads, sequences multi-byte peeks and assembles the
// result once the read data returns from memory.
// ----------------------------------------------------------------------------
module brbf_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  brbf_pkg::in_item_t             in_data_i,
  output logic                           in_stall_o,
  input  logic                           cfg_valid_i,
  input  logic [brbf_pkg::SIZE_W-1:0]    cfg_data_i,
  input  logic [1:0]                     occ_i,
  output brbf_pkg::res_push_t            push_o,
  output brbf_pkg::ram_req_t             ram_req_o,
  input  logic [7:0]                     ram_rdata_i
);
  import brbf_pkg::*;

  // Next slot index, wrapping at the slot count.
  function automatic logic [ADDR_W-1:0] step_idx(input logic [ADDR_W-1:0] idx,
                                                 input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] nxt;
    nxt = {1'b0, idx} + SIZE_W'(1);
    return (nxt >= size) ? '0 : nxt[ADDR_W-1:0];
  endfunction

  // Number of bytes held between tail and head.
  function automatic logic [ADDR_W-1:0] calc_level(input logic [ADDR_W-1:0] h,
                                                   input logic [ADDR_W-1:0] t,
                                                   input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] lv;
    if (step_idx(h, size) == t) begin
      lv = size - SIZE_W'(1);
    end else if (h >= t) begin
      lv = {1'b0, h} - {1'b0, t};
    end else begin
      lv = size + {1'b0, h} - {1'b0, t};
    end
    return lv[ADDR_W-1:0];
  endfunction

  state_e            state_q, state_d;
  logic [SIZE_W-1:0] size_q, size_clamped;
  logic [ADDR_W-1:0] head_q, head_d, tail_q, tail_d, pos_q, pos_d;
  logic [5:0]        rem_q, rem_d;
  logic              s1_valid_q, s1_valid_d;
  logic              s1_ok_q, s1_ok_d, s1_last_q, s1_last_d, s1_use_q, s1_use_d;
  logic              room, in_fire, full0, empty0;
  logic [ADDR_W-1:0] level0;

  // Issue only when the output queue is sure to have a free entry next cycle.
  assign room   = ((occ_i + {1'b0, s1_valid_q}) <= 2'd1);
  assign full0  = (step_idx(head_q, size_q) == tail_q);
  assign empty0 = (head_q == tail_q);
  assign level0 = calc_level(head_q, tail_q, size_q);

  // Clamp a written slot count into the supported range.
  always_comb begin
    if (cfg_data_i < RING_MIN) begin
      size_clamped = RING_MIN;
    end else if (cfg_data_i > RING_MAX) begin
      size_clamped = RING_MAX;
    end else begin
      size_clamped = cfg_data_i;
    end
  end

  // Command decode, peek sequencing and memory requests.
  always_comb begin
    state_d          = state_q;
    head_d           = head_q;
    tail_d           = tail_q;
    pos_d            = pos_q;
    rem_d            = rem_q;
    s1_valid_d       = 1'b0;
    s1_ok_d          = 1'b0;
    s1_last_d        = 1'b1;
    s1_use_d         = 1'b0;
    in_stall_o       = 1'b1;
    in_fire          = 1'b0;
    ram_req_o        = '0;
    ram_req_o.waddr  = head_q;
    ram_req_o.wdata  = in_data_i.write_byte;
    ram_req_o.raddr  = tail_q;

    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = !room;
        in_fire    = in_valid_i && room;
        if (in_fire) begin
          s1_valid_d = 1'b1;
          unique case (in_data_i.command)
            CMD_OVR_PUT: begin
              ram_req_o.we = 1'b1;
              head_d       = step_idx(head_q, size_q);
              if (full0) begin
                tail_d = step_idx(tail_q, size_q);
              end
              s1_ok_d = 1'b1;
            end
            CMD_TRY_PUT: begin
              if (!full0) begin
                ram_req_o.we = 1'b1;
                head_d       = step_idx(head_q, size_q);
                s1_ok_d      = 1'b1;
              end
            end
            CMD_GET: begin
              if (!empty0) begin
                ram_req_o.re = 1'b1;
                tail_d       = step_idx(tail_q, size_q);
                s1_ok_d      = 1'b1;
                s1_use_d     = 1'b1;
              end
            end
            CMD_PEEK: begin
              if (!empty0 && (in_data_i.peek_count <= level0)) begin
                s1_ok_d = 1'b1;
                if (in_data_i.peek_count != 6'd0) begin
                  ram_req_o.re = 1'b1;
                  s1_use_d     = 1'b1;
                  s1_last_d    = (in_data_i.peek_count == 6'd1);
                  if (in_data_i.peek_count != 6'd1) begin
                    state_d = ST_PEEK;
                    pos_d   = step_idx(tail_q, size_q);
                    rem_d   = in_data_i.peek_count - 6'd1;
                  end
                end
              end
            end
            CMD_RESET: begin
              head_d  = '0;
              tail_d  = '0;
              s1_ok_d = 1'b1;
            end
            default: begin
              s1_ok_d = 1'b0;
            end
          endcase
        end
      end
      ST_PEEK: begin
        // One peek byte per cycle while the output queue has room.
        ram_req_o.raddr = pos_q;
        if (room) begin
          ram_req_o.re = 1'b1;
          s1_valid_d   = 1'b1;
          s1_ok_d      = 1'b1;
          s1_use_d     = 1'b1;
          s1_last_d    = (rem_q == 6'd1);
          pos_d        = step_idx(pos_q, size_q);
          rem_d        = rem_q - 6'd1;
          if (rem_q == 6'd1) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // A slot count write empties the ring.
    if (cfg_valid_i) begin
      head_d = '0;
      tail_d = '0;
    end
  end

  // Result assembly: status is taken from the pointers after the command.
  always_comb begin
    push_o                  = '0;
    push_o.valid            = s1_valid_q;
    push_o.item.read_byte   = s1_use_q ? ram_rdata_i : 8'd0;
    push_o.item.ok          = s1_ok_q;
    push_o.item.level       = calc_level(head_q, tail_q, size_q);
    push_o.item.is_empty    = (head_q == tail_q);
    push_o.item.is_full     = (step_idx(head_q, size_q) == tail_q);
    push_o.item.last_of_run = s1_last_q;
  end

  // Control state and pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      size_q     <= RING_MAX;
      head_q     <= '0;
      tail_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      s1_valid_q <= s1_valid_d;
      if (cfg_valid_i) begin
        size_q <= size_clamped;
      end
    end
  end

  // Peek sequencer and result metadata.
  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    rem_q     <= rem_d;
    s1_ok_q   <= s1_ok_d;
    s1_last_q <= s1_last_d;
    s1_use_q  <= s1_use_d;
  end

endmodule

@@ bench/byte_ring_buffer_fifo_unit_test.sv @@
// ----------------------------------------------------------------------------
// byte_ring_buffer_fifo_unit_test
// Self-checking bench for the byte ring buffer FIFO. Command transactions go
// in through a valid/stall channel and a predictor in the bench works out
// the answers. Each answer is checked field by field as it leaves the block.
// Directed tests cover the corner cases, random traffic covers ring sizes
// including out-of-range ones, and one test holds off the output so the block fills up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module byte_ring_buffer_fifo_unit_test;
  import brbf_pkg::*;

  localparam int unsigned CLK_PERIOD     = 12;
  localparam int unsigned RESET_CYCLES   = 8;
  localparam int unsigned MAX_GAP        = 8;
  localparam int unsigned IDLE_GAP       = 4;
  localparam int unsigned DRAIN_CYCLES   = 16;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned TIMEOUT_CYCLES = 800000;

  // Command codes that the block does not define.
  localparam int unsigned CMD_UNDEF_FIRST = 5;
  localparam int unsigned CMD_UNDEF_LAST  = 7;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_item_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  out_item_t             out_data_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [SIZE_W-1:0]     cfg_data_i;

  // Predicted FIFO contents, pointers and effective ring size.
  logic [7:0]            ring_bytes [DEPTH];
  logic [ADDR_W-1:0]     head_ptr;
  logic [ADDR_W-1:0]     tail_ptr;
  int unsigned           ring_slots;

  // Answers owed by the block, oldest first.
  out_item_t             answers_due [$];

  int unsigned           error_count   = 0;
  bit                    tx_gaps_on    = 1'b1;
  bit                    rx_gaps_on    = 1'b1;
  int unsigned           rx_hold_cycles = 0;

  byte_ring_buffer_fifo_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  function automatic logic [ADDR_W-1:0] ring_next(input logic [ADDR_W-1:0] idx);
    int unsigned n;
    n = idx + 1;
    return (n >= ring_slots) ? '0 : ADDR_W'(n);
  endfunction

  function automatic bit ring_full();
    return ring_next(head_ptr) == tail_ptr;
  endfunction

  function automatic int unsigned ring_level();
    if (ring_full()) return ring_slots - 1;
    if (head_ptr >= tail_ptr) return head_ptr - tail_ptr;
    return ring_slots + head_ptr - tail_ptr;
  endfunction

  // Build an answer from the pointer state as it stands after the command.
  function automatic out_item_t answer_now(input logic [7:0] data, input bit ok,
                                           input bit last);
    out_item_t r;
    r.read_byte   = data;
    r.ok          = ok;
    r.level       = 6'(ring_level());
    r.is_empty    = (head_ptr == tail_ptr);
    r.is_full     = ring_full();
    r.last_of_run = last;
    return r;
  endfunction

  // Update the predicted FIFO for one command and queue its answers.
  function automatic void apply_command(input in_item_t item);
    logic [ADDR_W-1:0] pos;
    logic [7:0]        data;
    int unsigned       n;
    n = item.peek_count;
    case (item.command)
      CMD_OVR_PUT: begin
        ring_bytes[head_ptr] = item.write_byte;
        // A full ring drops its oldest byte.
        if (ring_full()) tail_ptr = ring_next(tail_ptr);
        head_ptr = ring_next(head_ptr);
        answers_due.push_back(answer_now(8'h00, 1'b1, 1'b1));
      end
      CMD_TRY_PUT: begin
        if (ring_full()) begin
          answers_due.push_back(answer_now(8'h00, 1'b0, 1'b1));
        end else begin
          ring_bytes[head_ptr] = item.write_byte;
          head_ptr = ring_next(head_ptr);
          answers_due.push_back(answer_now(8'h00, 1'b1, 1'b1));
        end
      end
      CMD_GET: begin
        if (head_ptr == tail_ptr) begin
          answers_due.push_back(answer_now(8'h00, 1'b0, 1'b1));
        end else begin
          data = ring_bytes[tail_ptr];
          tail_ptr = ring_next(tail_ptr);
          answers_due.push_back(answer_now(data, 1'b1, 1'b1));
        end
      end
      CMD_PEEK: begin
        if (head_ptr == tail_ptr || n > ring_level()) begin
          answers_due.push_back(answer_now(8'h00, 1'b0, 1'b1));
        end else if (n == 0) begin
          answers_due.push_back(answer_now(8'h00, 1'b1, 1'b1));
        end else begin
          pos = tail_ptr;
          for (int unsigned i = 0; i < n; i++) begin
            answers_due.push_back(answer_now(ring_bytes[pos], 1'b1, i + 1 == n));
            pos = ring_next(pos);
          end
        end
      end
      CMD_RESET: begin
        head_ptr = '0;
        tail_ptr = '0;
        answers_due.push_back(answer_now(8'h00, 1'b1, 1'b1));
      end
      default: begin
        answers_due.push_back(answer_now(8'h00, 1'b0, 1'b1));
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Output side: receiver with random stalls and an optional long hold.
  // --------------------------------------------------------------------------

  initial begin : answer_sink
    int unsigned gap;
    forever begin
      // A requested hold starts right after the answer just taken.
      if (rx_hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (rx_hold_cycles) @(posedge clk_i);
        rx_hold_cycles = 0;
      end
      gap = rx_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!(out_valid_o && !out_stall_i)) @(posedge clk_i);
    end
  end

  task automatic report_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // Compare every accepted answer with the oldest one predicted.
  always @(posedge clk_i) begin : answer_check
    out_item_t want;
    if (rst_ni === 1'b1 && out_valid_o && !out_stall_i) begin
      if (answers_due.size() == 0) begin
        $display("%0t ns: unexpected answer, expected none, actual %p", $time,
                 out_data_o);
        error_count++;
      end else begin
        want = answers_due.pop_front();
        report_field("read_byte", want.read_byte, out_data_o.read_byte);
        report_field("ok", want.ok, out_data_o.ok);
        report_field("level", want.level, out_data_o.level);
        report_field("is_empty", want.is_empty, out_data_o.is_empty);
        report_field("is_full", want.is_full, out_data_o.is_full);
        report_field("last_of_run", want.last_of_run, out_data_o.last_of_run);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Offer one command transaction and predict its answers once it is taken.
  task automatic issue_command(input logic [2:0] cmd, input logic [7:0] data,
                               input logic [5:0] count);
    in_item_t    item;
    int unsigned gap;
    item.command    = cmd;
    item.write_byte = data;
    item.peek_count = count;
    gap = tx_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    apply_command(item);
  endtask

  // Stop offering commands and let every owed answer come out.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (IDLE_GAP) @(posedge clk_i);
  endtask

  // Change the slot count; this also empties the ring.
  task automatic write_slot_count(input logic [SIZE_W-1:0] value);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (value < RING_MIN) ring_slots = RING_MIN;
    else if (value > RING_MAX) ring_slots = RING_MAX;
    else ring_slots = value;
    head_ptr = '0;
    tail_ptr = '0;
  endtask

  // One random command; put_pct sets how strongly the traffic fills the ring.
  task automatic random_command(input int unsigned put_pct);
    int unsigned roll;
    int unsigned count;
    logic [2:0]  cmd;
    roll  = $urandom_range(0, 99);
    count = $urandom_range(0, 63);
    if (roll < put_pct) begin
      cmd = $urandom_range(0, 1) ? CMD_OVR_PUT : CMD_TRY_PUT;
    end else if (roll < 80) begin
      cmd = CMD_GET;
    end else if (roll < 95) begin
      cmd = CMD_PEEK;
      // Mostly peek within reach of the level, sometimes anywhere.
      if ($urandom_range(0, 3) != 0) count = $urandom_range(0, ring_level() + 1);
      if (count > 63) count = 63;
    end else if (roll < 97) begin
      cmd = CMD_RESET;
    end else begin
      cmd = 3'($urandom_range(CMD_UNDEF_FIRST, CMD_UNDEF_LAST));
    end
    issue_command(cmd, 8'($urandom_range(0, 255)), 6'(count));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Refusals on an empty ring and the undefined command codes.
  task automatic test_empty_refusals();
    issue_command(CMD_GET, 8'h3C, 6'd0);
    issue_command(CMD_PEEK, 8'h00, 6'd0);
    for (int unsigned c = CMD_UNDEF_FIRST; c <= CMD_UNDEF_LAST; c++) begin
      issue_command(3'(c), 8'hFF, 6'd63);
    end
  endtask

  // Basic puts, peeks in and out of reach, get and pointer reset.
  task automatic test_put_peek_get();
    issue_command(CMD_TRY_PUT, 8'h00, 6'd0);
    issue_command(CMD_OVR_PUT, 8'hFF, 6'd63);
    issue_command(CMD_PEEK, 8'h12, 6'd0);
    issue_command(CMD_PEEK, 8'h34, 6'd2);
    issue_command(CMD_PEEK, 8'h56, 6'd3);
    issue_command(CMD_PEEK, 8'h78, 6'd63);
    issue_command(CMD_GET, 8'h9A, 6'd1);
    issue_command(CMD_RESET, 8'hBC, 6'd5);
    issue_command(CMD_GET, 8'hDE, 6'd0);
  endtask

  // Smallest ring: one byte fills it, so both full cases show up at once.
  task automatic test_two_slot_ring();
    write_slot_count(SIZE_W'(2));
    issue_command(CMD_TRY_PUT, 8'h5A, 6'd0);
    issue_command(CMD_TRY_PUT, 8'h11, 6'd0);
    issue_command(CMD_OVR_PUT, 8'h22, 6'd0);
    issue_command(CMD_PEEK, 8'h00, 6'd1);
    issue_command(CMD_GET, 8'h00, 6'd0);
    issue_command(CMD_GET, 8'h00, 6'd0);
  endtask

  // Largest ring filled to the top, with one peek of the whole content.
  task automatic test_full_ring();
    write_slot_count('1);
    tx_gaps_on = 1'b0;
    repeat (DEPTH - 1) issue_command(CMD_TRY_PUT, 8'($urandom_range(0, 255)), 6'd0);
    tx_gaps_on = 1'b1;
    issue_command(CMD_TRY_PUT, 8'hA5, 6'd0);
    issue_command(CMD_PEEK, 8'h00, 6'd63);
    issue_command(CMD_OVR_PUT, 8'h5A, 6'd0);
    issue_command(CMD_GET, 8'h00, 6'd0);
    issue_command(CMD_GET, 8'h00, 6'd0);
  endtask

  // Random traffic over a spread of slot counts, including out-of-range ones.
  task automatic test_random_traffic();
    logic [SIZE_W-1:0] ring_sizes [8] = '{7'd3, 7'd0, 7'd5, 7'd65, 7'd1, 7'd9,
                                          7'd4, 7'd64};
    foreach (ring_sizes[k]) begin
      write_slot_count(ring_sizes[k]);
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      rx_gaps_on = ($urandom_range(0, 3) != 0);
      for (int unsigned i = 0; i < 2; i++) begin
        random_command((i % 2 == 0) ? 60 : 25);
      end
    end
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  // Hold the output off for a long stretch while commands keep coming.
  task automatic test_output_backpressure();
    write_slot_count(SIZE_W'(16));
    tx_gaps_on     = 1'b0;
    rx_hold_cycles = HOLD_CYCLES;
    repeat (8) random_command(50);
    tx_gaps_on = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin : run_tests
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    ring_slots  = DEPTH;
    head_ptr    = '0;
    tail_ptr    = '0;
    foreach (ring_bytes[i]) ring_bytes[i] = 8'h00;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_refusals();
    test_put_peek_get();
    test_two_slot_ring();
    test_full_ring();
    test_random_traffic();
    test_output_backpressure();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog for a block that hangs.
  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ sim.f @@
src/brbf_pkg.sv
src/brbf_ram.sv
src/brbf_outq.sv
src/brbf_ctrl.sv
src/byte_ring_buffer_fifo_unit.sv
bench/byte_ring_buffer_fifo_unit_test.sv
